### hdl/lod_pkg.sv
// ----------------------------------------------------------------------------
// lod_pkg
// Shared types and fixed widths for the label overlap meter.
// ----------------------------------------------------------------------------
package lod_pkg;

    // Fixed port widths
    localparam int PIXEL_BITS     = 16;
    localparam int OUT_COUNT_BITS = 32;
    localparam int OUT_RATIO_BITS = 17;

    localparam logic [PIXEL_BITS-1:0] TARGET_RESET = 16'd1;

    // Depth of the region queue between the counter and the divider
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } lod_queue_status_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_SEND = 3'b100
    } lod_back_state_t;

endpackage

### hdl/lod_front.sv
// ----------------------------------------------------------------------------
// lod_front
// Per-pixel match counters; hands the totals of each region to the queue.
// ----------------------------------------------------------------------------
module lod_front
    import lod_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int LABEL_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [PIXEL_BITS-1:0]   pixel_first,
    input  logic [PIXEL_BITS-1:0]   pixel_second,
    input  logic                    last_pixel,
    input  logic [PIXEL_BITS-1:0]   target_label,
    input  lod_queue_status_t       q_status,
    output logic                    push,
    output logic [3*COUNT_BITS-1:0] push_data
);

    localparam int CMP_BITS = (LABEL_BITS < PIXEL_BITS) ? LABEL_BITS : PIXEL_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] first_reg, first_next, first_new;
    logic [COUNT_BITS-1:0] second_reg, second_next, second_new;
    logic [COUNT_BITS-1:0] joint_reg, joint_next, joint_new;
    logic                  m_first, m_second, accept;

    assign m_first  = (pixel_first[CMP_BITS-1:0] == target_label[CMP_BITS-1:0]);
    assign m_second = (pixel_second[CMP_BITS-1:0] == target_label[CMP_BITS-1:0]);

    assign in_stall = q_status.full;
    assign accept   = in_valid & ~q_status.full;
    assign push     = accept & last_pixel;

    // Saturating increments, this pair included
    always_comb
    begin
        first_new  = first_reg;
        second_new = second_reg;
        joint_new  = joint_reg;
        if (m_first && first_reg != CNT_MAX)
            first_new = first_reg + 1'b1;
        if (m_second && second_reg != CNT_MAX)
            second_new = second_reg + 1'b1;
        if (m_first && m_second && joint_reg != CNT_MAX)
            joint_new = joint_reg + 1'b1;
    end

    assign push_data = {first_new, second_new, joint_new};

    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        joint_next  = joint_reg;
        if (accept)
        begin
            // drop the totals once the region is handed over
            first_next  = last_pixel ? '0 : first_new;
            second_next = last_pixel ? '0 : second_new;
            joint_next  = last_pixel ? '0 : joint_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
            joint_reg  <= '0;
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            joint_reg  <= joint_next;
        end
    end

    a_joint_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (joint_reg <= first_reg) && (joint_reg <= second_reg))
        else $error("joint count exceeds a single-image count");

endmodule

### hdl/lod_queue.sv
// ----------------------------------------------------------------------------
// lod_queue
// Short FIFO of finished region totals between counter and divider.
// ----------------------------------------------------------------------------
module lod_queue
    import lod_pkg::*;
#(
    parameter int WIDTH = 96
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [WIDTH-1:0]  push_data,
    input  logic              pop,
    output logic [WIDTH-1:0]  pop_data,
    output lod_queue_status_t q_status
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(QUEUE_DEPTH);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);

    logic [WIDTH-1:0]    slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == DEPTH_C);
    assign q_status.empty = (count_reg == '0);
    assign pop_data       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("push into full region queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty region queue");

endmodule

### hdl/lod_back.sv
// ----------------------------------------------------------------------------
// lod_back
// Restoring divider for Dice and Jaccard ratios plus the result register.
// ----------------------------------------------------------------------------
module lod_back
    import lod_pkg::*;
#(
    parameter int COUNT_BITS    = 32,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lod_queue_status_t         q_status,
    input  logic [3*COUNT_BITS-1:0]   pop_data,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [OUT_COUNT_BITS-1:0] count_first,
    output logic [OUT_COUNT_BITS-1:0] count_second,
    output logic [OUT_COUNT_BITS-1:0] count_both,
    output logic [OUT_RATIO_BITS-1:0] dice_ratio,
    output logic [OUT_RATIO_BITS-1:0] jaccard_ratio,
    output logic                      empty_flag
);

    localparam int C    = COUNT_BITS;
    localparam int F    = FRACTION_BITS;
    localparam int RW   = C + 2;
    localparam int STEP_BITS = $clog2(F);
    localparam int CW   = (C > OUT_COUNT_BITS) ? C : OUT_COUNT_BITS;
    localparam int WIDE = (F + 1 > OUT_RATIO_BITS) ? F + 1 : OUT_RATIO_BITS;
    localparam logic [STEP_BITS-1:0] STEP_INIT = STEP_BITS'(F - 1);
    localparam logic [WIDE-1:0] ONE_W = WIDE'(1) << F;

    lod_back_state_t state_reg, state_next;

    logic [C-1:0]         first_in, second_in, both_in;
    logic [C:0]           sum_in, diff_in, num_d_in;
    logic [C-1:0]         first_reg, second_reg, both_reg;
    logic [C:0]           den_d_reg, den_j_reg;
    logic [RW-1:0]        rem_d_reg, rem_j_reg;
    logic [RW-1:0]        trial_d, trial_j;
    logic                 ge_d, ge_j;
    logic [F-1:0]         q_d_reg, q_j_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 empty_reg, full_d_reg, full_j_reg;
    logic                 load_out, out_valid_reg, out_valid_next;
    logic [WIDE-1:0]      dice_w, jac_w;
    logic [CW-1:0]        first_w, second_w, both_w;

    assign {first_in, second_in, both_in} = pop_data;
    assign sum_in   = {1'b0, first_in} + {1'b0, second_in};
    assign diff_in  = sum_in - {1'b0, both_in};
    assign num_d_in = {both_in, 1'b0};

    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;
    assign load_out = (state_reg == ST_SEND) && (!out_valid_reg || !out_stall);

    // One quotient bit per cycle for each ratio
    assign trial_d = {rem_d_reg[RW-2:0], 1'b0};
    assign trial_j = {rem_j_reg[RW-2:0], 1'b0};
    assign ge_d    = trial_d >= {1'b0, den_d_reg};
    assign ge_j    = trial_j >= {1'b0, den_j_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (pop)
                    state_next = ST_DIV;
            ST_DIV:
                if (step_reg == '0)
                    state_next = ST_SEND;
            ST_SEND:
                if (load_out)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            first_reg  <= first_in;
            second_reg <= second_in;
            both_reg   <= both_in;
            den_d_reg  <= sum_in;
            den_j_reg  <= diff_in;
            rem_d_reg  <= {1'b0, num_d_in};
            rem_j_reg  <= {2'b00, both_in};
            empty_reg  <= (first_in == '0) && (second_in == '0);
            full_d_reg <= num_d_in >= sum_in;
            full_j_reg <= {1'b0, both_in} >= diff_in;
            step_reg   <= STEP_INIT;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_d_reg <= ge_d ? trial_d - {1'b0, den_d_reg} : trial_d;
            rem_j_reg <= ge_j ? trial_j - {1'b0, den_j_reg} : trial_j;
            q_d_reg   <= {q_d_reg[F-2:0], ge_d};
            q_j_reg   <= {q_j_reg[F-2:0], ge_j};
            step_reg  <= step_reg - 1'b1;
        end
    end

    always_comb
    begin
        if (empty_reg)
            dice_w = '0;
        else if (full_d_reg)
            dice_w = ONE_W;
        else
            dice_w = WIDE'(q_d_reg);
        if (empty_reg)
            jac_w = '0;
        else if (full_j_reg)
            jac_w = ONE_W;
        else
            jac_w = WIDE'(q_j_reg);
    end

    assign first_w  = CW'(first_reg);
    assign second_w = CW'(second_reg);
    assign both_w   = CW'(both_reg);

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            count_first   <= first_w[OUT_COUNT_BITS-1:0];
            count_second  <= second_w[OUT_COUNT_BITS-1:0];
            count_both    <= both_w[OUT_COUNT_BITS-1:0];
            dice_ratio    <= dice_w[OUT_RATIO_BITS-1:0];
            jaccard_ratio <= jac_w[OUT_RATIO_BITS-1:0];
            empty_flag    <= empty_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_flag) |-> (dice_ratio == '0 && jaccard_ratio == '0))
        else $error("empty region with nonzero ratio");

    a_pop_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_DIV))
        else $error("divider did not start after pop");

    a_both_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && C <= OUT_COUNT_BITS) |->
            (count_both <= count_first && count_both <= count_second))
        else $error("joint count above single-image count in result");

endmodule

### hdl/label_overlap_dice_jaccard.sv
// ----------------------------------------------------------------------------
// label_overlap_dice_jaccard
// Dice and Jaccard overlap meter for one target label over two label images.
// ----------------------------------------------------------------------------
// Pixel pairs enter one word per cycle on the in channel unless in_stall is
// high. Each pixel matching target_label bumps a saturating counter (first,
// second, both). The pair flagged last_pixel closes a region: its totals go
// into a two-entry queue and the counters clear, so the next region streams
// in right behind it unless the queue is full. A restoring divider behind the
// queue computes both ratios side by side, one quotient bit per cycle; each
// region passes through the back end as one pop, FRACTION_BITS divide steps
// and one load into the result register. Pixel throughput is one pair per
// cycle while the queue has room; the input only stalls once two finished
// regions are waiting. Results are Q1.FRACTION_BITS fractions truncated
// toward zero; an exact 1.0 is 2^FRACTION_BITS, and an empty region reports
// zero ratios with empty_flag. Write target_label only while the block is idle.
// ----------------------------------------------------------------------------
module label_overlap_dice_jaccard
    import lod_pkg::*;
#(
    parameter int COUNT_BITS    = 32,
    parameter int LABEL_BITS    = 16,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [PIXEL_BITS-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [PIXEL_BITS-1:0]     pixel_first,
    input  logic [PIXEL_BITS-1:0]     pixel_second,
    input  logic                      last_pixel,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [OUT_COUNT_BITS-1:0] count_first,
    output logic [OUT_COUNT_BITS-1:0] count_second,
    output logic [OUT_COUNT_BITS-1:0] count_both,
    output logic [OUT_RATIO_BITS-1:0] dice_ratio,
    output logic [OUT_RATIO_BITS-1:0] jaccard_ratio,
    output logic                      empty_flag
);

    localparam int QW = 3 * COUNT_BITS;

    logic [PIXEL_BITS-1:0] target_reg;
    lod_queue_status_t     q_status;
    logic                  push, pop;
    logic [QW-1:0]         push_data, pop_data;

    // Hold the target label; reset selects label 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= TARGET_RESET;
        else if (cfg_write)
            target_reg <= cfg_data;
    end

    // Front end: classify each pair and advance the counters
    lod_front #(
        .COUNT_BITS (COUNT_BITS),
        .LABEL_BITS (LABEL_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_first  (pixel_first),
        .pixel_second (pixel_second),
        .last_pixel   (last_pixel),
        .target_label (target_reg),
        .q_status     (q_status),
        .push         (push),
        .push_data    (push_data)
    );

    // Decouple counting from division
    lod_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    // Back end: divide and present the result word
    lod_back #(
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .pop_data      (pop_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .count_first   (count_first),
        .count_second  (count_second),
        .count_both    (count_both),
        .dice_ratio    (dice_ratio),
        .jaccard_ratio (jaccard_ratio),
        .empty_flag    (empty_flag)
    );

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Dice/Jaccard label overlap meter.
// ----------------------------------------------------------------------------
// A queue of pixel-pair words is filled phase by phase, one target label per
// phase. A clocked driver feeds the words with random gaps. Every accepted
// word runs through a local predictor that keeps its own match counters and
// turns each closed region into one expected result word. A clocked monitor
// stalls at random and compares every result word, field by field, with the
// oldest expected word. The target label is rewritten only between phases,
// once the meter has gone quiet.
// ----------------------------------------------------------------------------
module tb_top;
    import lod_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int FRAC_BITS     = 16;
    localparam int MAX_WAIT      = 18;
    // Back end: one pop, FRAC_BITS divide steps, one load
    localparam int BACKEND_CYCLES = FRAC_BITS + 2;
    localparam int SETTLE_CYCLES  = 3 * BACKEND_CYCLES + 8;
    localparam int DRAIN_LIMIT    = 4000;
    localparam int PHASE_PAIRS    = 150;
    localparam int PHASE_COUNT    = 5;
    localparam int PRINT_CAP      = 100;

    localparam logic [OUT_RATIO_BITS-1:0] UNITY_Q16 = 17'h10000;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] first_label;
        logic [PIXEL_BITS-1:0] second_label;
        logic                  closes_region;
    } pixel_pair_t;

    typedef struct packed {
        logic [OUT_COUNT_BITS-1:0] first_hits;
        logic [OUT_COUNT_BITS-1:0] second_hits;
        logic [OUT_COUNT_BITS-1:0] joint_hits;
        logic [OUT_RATIO_BITS-1:0] dice;
        logic [OUT_RATIO_BITS-1:0] jaccard;
        logic                      no_match;
    } overlap_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_write    = 1'b0;
    logic [PIXEL_BITS-1:0]     cfg_data     = '0;
    logic                      in_valid     = 1'b0;
    logic                      in_stall;
    logic [PIXEL_BITS-1:0]     pixel_first  = '0;
    logic [PIXEL_BITS-1:0]     pixel_second = '0;
    logic                      last_pixel   = 1'b0;
    logic                      out_valid;
    logic                      out_stall    = 1'b0;
    logic [OUT_COUNT_BITS-1:0] count_first;
    logic [OUT_COUNT_BITS-1:0] count_second;
    logic [OUT_COUNT_BITS-1:0] count_both;
    logic [OUT_RATIO_BITS-1:0] dice_ratio;
    logic [OUT_RATIO_BITS-1:0] jaccard_ratio;
    logic                      empty_flag;

    // Predictor state: a private copy of the target and the three tallies
    logic [PIXEL_BITS-1:0]     target_copy  = TARGET_RESET;
    logic [OUT_COUNT_BITS-1:0] first_tally  = '0;
    logic [OUT_COUNT_BITS-1:0] second_tally = '0;
    logic [OUT_COUNT_BITS-1:0] joint_tally  = '0;

    pixel_pair_t pair_backlog[$];
    overlap_t    overlap_expected[$];

    pixel_pair_t next_pair;
    overlap_t    wanted_word;
    int          gap_left        = 0;
    int          stall_left      = 0;
    int          stall_draw      = 0;
    bit          sender_calm     = 1'b0;
    bit          receiver_calm   = 1'b0;

    int pairs_queued    = 0;
    int pairs_taken     = 0;
    int regions_closed  = 0;
    int empty_regions   = 0;
    int full_regions    = 0;
    int targets_used    = 1;
    int results_checked = 0;
    int mismatch_count  = 0;

    label_overlap_dice_jaccard dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_first   (pixel_first),
        .pixel_second  (pixel_second),
        .last_pixel    (last_pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .count_first   (count_first),
        .count_second  (count_second),
        .count_both    (count_both),
        .dice_ratio    (dice_ratio),
        .jaccard_ratio (jaccard_ratio),
        .empty_flag    (empty_flag)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic compare_field(input string field, input logic [OUT_COUNT_BITS-1:0] seen,
                                 input logic [OUT_COUNT_BITS-1:0] wanted);
        if (seen !== wanted)
            flag_mismatch($sformatf("%s is %0d, expected %0d", field, seen, wanted));
    endtask

    // ------------------------------------------------------------------------
    // Overlap predictor
    // ------------------------------------------------------------------------

    // Hold a tally at all ones once it gets there
    function automatic logic [OUT_COUNT_BITS-1:0] bump(input logic [OUT_COUNT_BITS-1:0] tally);
        return (&tally) ? tally : tally + 1'b1;
    endfunction

    // floor(num * 2^16 / den), clipped to exactly 1.0 when num reaches den; zero when den is zero
    function automatic logic [OUT_RATIO_BITS-1:0] q16_fraction(input logic [63:0] num,
                                                              input logic [63:0] den);
        logic [63:0] scaled;
        if (den == 64'd0)
            return '0;
        if (num >= den)
            return UNITY_Q16;
        scaled = (num << FRAC_BITS) / den;
        return scaled[OUT_RATIO_BITS-1:0];
    endfunction

    // Count one accepted pair; on the closing pair, queue the region's word
    // and clear the tallies for the next region.
    task automatic tally_pair(input pixel_pair_t pair);
        logic        hit_first;
        logic        hit_second;
        logic [63:0] span;
        overlap_t    region;
        hit_first  = (pair.first_label == target_copy);
        hit_second = (pair.second_label == target_copy);
        if (hit_first)
            first_tally = bump(first_tally);
        if (hit_second)
            second_tally = bump(second_tally);
        if (hit_first && hit_second)
            joint_tally = bump(joint_tally);
        pairs_taken++;
        if (pair.closes_region)
        begin
            region.first_hits  = first_tally;
            region.second_hits = second_tally;
            region.joint_hits  = joint_tally;
            region.no_match    = (first_tally == '0) && (second_tally == '0);
            region.dice        = '0;
            region.jaccard     = '0;
            if (!region.no_match)
            begin
                span           = 64'(first_tally) + 64'(second_tally);
                region.dice    = q16_fraction(64'(joint_tally) << 1, span);
                region.jaccard = q16_fraction(64'(joint_tally), span - 64'(joint_tally));
            end
            regions_closed++;
            if (region.no_match)
                empty_regions++;
            if (region.dice == UNITY_Q16)
                full_regions++;
            overlap_expected.push_back(region);
            first_tally  = '0;
            second_tally = '0;
            joint_tally  = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: present one pair word at a time from the backlog. Every word
    // draws the idle gap that precedes the next one; calm stretches draw none.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            pixel_first  <= '0;
            pixel_second <= '0;
            last_pixel   <= 1'b0;
            gap_left     <= 0;
        end
        else
        begin
            // Predict from the word the meter takes on this edge
            if (in_valid && !in_stall)
                tally_pair({pixel_first, pixel_second, last_pixel});
            // Hold the payload while stalled; otherwise advance
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pair_backlog.size() > 0)
                begin
                    next_pair = pair_backlog.pop_front();
                    pixel_first  <= next_pair.first_label;
                    pixel_second <= next_pair.second_label;
                    last_pixel   <= next_pair.closes_region;
                    in_valid     <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        sender_calm = !sender_calm;
                    gap_left <= sender_calm ? 0 : int'($urandom_range(0, MAX_WAIT));
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted result word against the oldest expected
    // word, then draw how long to stall before the next one. The stall
    // counts down whether or not a word is on offer.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (overlap_expected.size() == 0)
            begin
                flag_mismatch($sformatf("result word with no region pending (counts %0d %0d %0d)",
                                        count_first, count_second, count_both));
            end
            else
            begin
                wanted_word = overlap_expected.pop_front();
                compare_field("count_first", count_first, wanted_word.first_hits);
                compare_field("count_second", count_second, wanted_word.second_hits);
                compare_field("count_both", count_both, wanted_word.joint_hits);
                compare_field("dice_ratio", OUT_COUNT_BITS'(dice_ratio),
                              OUT_COUNT_BITS'(wanted_word.dice));
                compare_field("jaccard_ratio", OUT_COUNT_BITS'(jaccard_ratio),
                              OUT_COUNT_BITS'(wanted_word.jaccard));
                compare_field("empty_flag", OUT_COUNT_BITS'(empty_flag),
                              OUT_COUNT_BITS'(wanted_word.no_match));
                results_checked++;
            end
            if ($urandom_range(0, 39) == 0)
                receiver_calm = !receiver_calm;
            stall_draw = receiver_calm ? 0 : int'($urandom_range(0, MAX_WAIT));
            stall_left <= stall_draw;
            out_stall  <= (stall_draw != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_pair(input logic [PIXEL_BITS-1:0] first_label,
                              input logic [PIXEL_BITS-1:0] second_label,
                              input logic closes_region);
        pair_backlog.push_back({first_label, second_label, closes_region});
        pairs_queued++;
    endtask

    // Write the target only while the meter is quiet
    task automatic write_target(input logic [PIXEL_BITS-1:0] label);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= label;
        @(posedge clk);
        cfg_write   <= 1'b0;
        target_copy = label;
        targets_used++;
    endtask

    // Density 0 never picks the target on purpose, density 4 always does;
    // misses lean toward near misses and the all-zero/all-one labels.
    function automatic logic [PIXEL_BITS-1:0] pick_label(input int density);
        logic [PIXEL_BITS-1:0] label;
        if (int'($urandom_range(0, 3)) < density)
            return target_copy;
        case ($urandom_range(0, 3))
            0:       label = target_copy ^ (16'd1 << $urandom_range(0, PIXEL_BITS - 1));
            1:       label = $urandom_range(0, 1) ? '1 : '0;
            default: label = PIXEL_BITS'($urandom());
        endcase
        return label;
    endfunction

    // Queue whole regions, mostly short, now and then long
    task automatic fill_regions(input int pair_goal);
        int made;
        int run;
        int pick;
        int density;
        made = 0;
        while (made < pair_goal)
        begin
            pick = int'($urandom_range(0, 19));
            if (pick < 16)
                run = int'($urandom_range(1, 8));
            else if (pick < 19)
                run = int'($urandom_range(9, 40));
            else
                run = int'($urandom_range(41, 120));
            density = int'($urandom_range(0, 4));
            for (int k = 0; k < run; k++)
                queue_pair(pick_label(density), pick_label(density), k == run - 1);
            made += run;
        end
    endtask

    // Wait for every queued word to go in and every expected word to come
    // out, then let the divider settle before any register write.
    task automatic drain_phase();
        int waited;
        while (pairs_taken != pairs_queued)
            @(posedge clk);
        waited = 0;
        while (overlap_expected.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (overlap_expected.size() != 0)
        begin
            flag_mismatch($sformatf("%0d expected result words never arrived",
                                    overlap_expected.size()));
            overlap_expected.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [PIXEL_BITS-1:0] phase_target;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset target (1): empty region, exact overlap, half overlap,
        // first-only and second-only matches, near-miss labels.
        queue_pair(16'h0000, 16'h0000, 1'b1);
        queue_pair(16'h0001, 16'h0001, 1'b1);
        queue_pair(16'h0001, 16'h0000, 1'b0);
        queue_pair(16'h0000, 16'h0001, 1'b0);
        queue_pair(16'h0001, 16'h0001, 1'b1);
        queue_pair(16'h0001, 16'h0002, 1'b0);
        queue_pair(16'h0001, 16'hFFFF, 1'b1);
        queue_pair(16'hFFFF, 16'h0001, 1'b1);
        queue_pair(16'h8001, 16'h0003, 1'b0);
        queue_pair(16'h0001, 16'h0001, 1'b1);
        drain_phase();

        // Lowest target: all-zero labels match, all-one labels do not
        write_target(16'h0000);
        queue_pair(16'h0000, 16'h0000, 1'b1);
        queue_pair(16'hFFFF, 16'hFFFF, 1'b0);
        queue_pair(16'h0000, 16'hFFFF, 1'b0);
        queue_pair(16'h0000, 16'h0000, 1'b1);
        queue_pair(16'hFFFF, 16'hFFFF, 1'b1);
        drain_phase();

        // Highest target, with single-bit misses on both ends of the word
        write_target(16'hFFFF);
        queue_pair(16'hFFFF, 16'hFFFF, 1'b1);
        queue_pair(16'hFFFF, 16'h0000, 1'b0);
        queue_pair(16'hFFFE, 16'hFFFF, 1'b0);
        queue_pair(16'h7FFF, 16'hFFFF, 1'b0);
        queue_pair(16'hFFFF, 16'hFFFF, 1'b1);
        drain_phase();

        // Random regions, one target per phase, extremes included
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                1:       phase_target = '0;
                2:       phase_target = '1;
                default: phase_target = PIXEL_BITS'($urandom());
            endcase
            write_target(phase_target);
            fill_regions(PHASE_PAIRS);
            drain_phase();
        end

        $display("covered %0d pixel words in %0d regions (%0d empty, %0d full overlap), %0d targets",
                 pairs_taken, regions_closed, empty_regions, full_regions, targets_used);
        $display("checked %0d result words, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
hdl/lod_pkg.sv
hdl/lod_front.sv
hdl/lod_queue.sv
hdl/lod_back.sv
hdl/label_overlap_dice_jaccard.sv
tb/sv/tb_top.sv
